// ===== rtl/spmd_pkg.sv =====
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants for the signal pending mask dispatcher.
// ----------------------------------------------------------------------------
package spmd_pkg;

  localparam int SIG_W       = 32;
  localparam int SIG_NUM_W   = 5;
  localparam int EXIT_W      = 8;
  localparam int REG_IDX_W   = 2;

  localparam int NUM_SIGNALS_DEF = 32;
  localparam int KILL_SIGNAL_DEF = 9;
  localparam int TERM_SIGNAL_DEF = 15;

  localparam logic [REG_IDX_W-1:0] REG_BLOCKED = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUSTOM  = 2'd2;

  localparam logic REQ_SEND  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [SIG_NUM_W-1:0] sig_num;
  } req_t;

  typedef struct packed {
    logic                 delivered;
    logic [SIG_NUM_W-1:0] sig_out;
    logic                 terminated;
    logic [EXIT_W-1:0]    exit_code;
  } result_t;

  typedef struct packed {
    logic [SIG_W-1:0] blocked_mask;
    logic [SIG_W-1:0] ignore_mask;
    logic [SIG_W-1:0] custom_mask;
  } masks_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// ===== rtl/spmd_cfg.sv =====
// ----------------------------------------------------------------------------
// spmd_cfg
// Configuration register file for the block, ignore and handler masks.
// ----------------------------------------------------------------------------
module spmd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spmd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [spmd_pkg::SIG_W-1:0]      cfg_data,
  output spmd_pkg::masks_t                masks
);
  import spmd_pkg::*;

  masks_t regs;

  assign cfg_ready = 1'b1;
  assign masks     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCKED: begin
          regs.blocked_mask <= cfg_data;
        end
        REG_IGNORE: begin
          regs.ignore_mask <= cfg_data;
        end
        REG_CUSTOM: begin
          regs.custom_mask <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/spmd_scan.sv =====
// ----------------------------------------------------------------------------
// spmd_scan
// Pending bits and the bit-serial dispatch scan, one signal number per cycle.
// ----------------------------------------------------------------------------
module spmd_scan #(
  parameter int NUM_SIGNALS = spmd_pkg::NUM_SIGNALS_DEF,
  parameter int KILL_SIGNAL = spmd_pkg::KILL_SIGNAL_DEF,
  parameter int TERM_SIGNAL = spmd_pkg::TERM_SIGNAL_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  spmd_pkg::req_t      req,
  input  spmd_pkg::masks_t    masks,
  output logic                done,
  output spmd_pkg::result_t   result
);
  import spmd_pkg::*;

  localparam int LIM = (NUM_SIGNALS > SIG_W) ? SIG_W : NUM_SIGNALS;
  localparam logic [SIG_NUM_W:0]   LIM_W  = (SIG_NUM_W+1)'(LIM);
  localparam logic [SIG_NUM_W:0]   KILL_W = (SIG_NUM_W+1)'(KILL_SIGNAL);
  localparam logic [SIG_NUM_W:0]   TERM_W = (SIG_NUM_W+1)'(TERM_SIGNAL);
  localparam logic [SIG_NUM_W-1:0] LAST   = SIG_NUM_W'(SIG_W - 1);

  state_t               state;
  logic [SIG_W-1:0]     pend;
  logic [SIG_W-1:0]     blk_sh;
  logic [SIG_W-1:0]     ign_sh;
  logic [SIG_W-1:0]     cus_sh;
  logic [SIG_NUM_W-1:0] cnt;
  logic                 found;
  logic                 fatal;
  logic [SIG_NUM_W-1:0] hit_sig;

  logic                 accept;
  logic                 send_ok;
  logic                 active;
  logic                 visit;
  logic                 take_custom;
  logic                 take_fatal;
  logic                 pend_bit_next;
  logic                 is_fatal_num;

  assign busy    = (state == ST_SCAN);
  assign accept  = start && !busy;
  assign send_ok = (req.sig_num != '0) && ({1'b0, req.sig_num} < LIM_W);

  // the pending word rotates once round per scan, bit 0 is signal cnt
  assign active        = !found && (cnt != '0) && ({1'b0, cnt} < LIM_W);
  assign visit         = active && pend[0] && !blk_sh[0];
  assign is_fatal_num  = ({1'b0, cnt} == KILL_W) || ({1'b0, cnt} == TERM_W);
  assign take_custom   = visit && !ign_sh[0] && cus_sh[0];
  assign take_fatal    = visit && !ign_sh[0] && !cus_sh[0] && is_fatal_num;
  assign pend_bit_next = visit ? 1'b0 : pend[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= '0;
      done  <= 1'b0;
      cnt   <= '0;
      found <= 1'b0;
      fatal <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_CHECK) begin
              state  <= ST_SCAN;
              blk_sh <= masks.blocked_mask;
              ign_sh <= masks.ignore_mask;
              cus_sh <= masks.custom_mask;
              cnt    <= '0;
              found  <= 1'b0;
              fatal  <= 1'b0;
            end else if (send_ok) begin
              pend <= pend | (SIG_W'(1) << req.sig_num);
            end
          end
        end
        ST_SCAN: begin
          pend   <= {pend_bit_next, pend[SIG_W-1:1]};
          blk_sh <= {1'b0, blk_sh[SIG_W-1:1]};
          ign_sh <= {1'b0, ign_sh[SIG_W-1:1]};
          cus_sh <= {1'b0, cus_sh[SIG_W-1:1]};
          cnt    <= cnt + 1'b1;
          if (take_custom || take_fatal) begin
            found   <= 1'b1;
            fatal   <= take_fatal;
            hit_sig <= cnt;
          end
          if (cnt == LAST) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result            = '0;
    result.delivered  = found;
    result.sig_out    = found ? hit_sig : '0;
    result.terminated = found && fatal;
    result.exit_code  = (found && fatal) ?
                        {3'b100, hit_sig} : '0;
  end

  // checks
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("result strobe without a scan");

  a_scan_runs_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt != LAST) |=> (state == ST_SCAN))
    else $error("scan ended before the pending word came round");

  a_term_delivered: assert property (@(posedge clk) disable iff (rst)
    (done && result.terminated) |-> (result.delivered && result.sig_out != '0))
    else $error("termination without a delivered signal");

  a_bit0_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend[0])
    else $error("signal zero pending");

  a_no_found_on_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == '0) |-> !found)
    else $error("hit recorded before the scan started");

endmodule

// ===== rtl/signal_pending_mask_dispatcher.sv =====
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatcher
// Per-process signal controller: pending bits, masks and priority dispatch.
// ----------------------------------------------------------------------------
// send: taken while idle, no result, busy stays low
// check: one signal number a cycle through the rotating pending word, result
//   strobed on done in the cycle after the last; next item taken in that cycle
// receiver cannot stall, each result shows on done for one cycle only
// synchronous reset clears the masks, the pending bits and the scan state
module signal_pending_mask_dispatcher #(
  parameter int NUM_SIGNALS = spmd_pkg::NUM_SIGNALS_DEF,
  parameter int KILL_SIGNAL = spmd_pkg::KILL_SIGNAL_DEF,
  parameter int TERM_SIGNAL = spmd_pkg::TERM_SIGNAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  spmd_pkg::req_t                  req,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spmd_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [spmd_pkg::SIG_W-1:0]      cfg_data,
  output logic                            done,
  output spmd_pkg::result_t               result
);
  import spmd_pkg::*;

  masks_t masks;

  spmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .masks     (masks)
  );

  spmd_scan #(
    .NUM_SIGNALS (NUM_SIGNALS),
    .KILL_SIGNAL (KILL_SIGNAL),
    .TERM_SIGNAL (TERM_SIGNAL)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .masks  (masks),
    .done   (done),
    .result (result)
  );

endmodule
